[rtl/sle_pkg.sv]
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants for the serial line editor with echo.
// ----------------------------------------------------------------------------
package sle_pkg;

    // Line store size in bytes. Legal range 4 to 256.
    localparam int LINE_CAPACITY = 64;
    localparam int ADDR_W        = $clog2(LINE_CAPACITY);

    // Most bytes a line may hold before further characters are dropped.
    localparam logic [ADDR_W-1:0] FILL_MAX = ADDR_W'(LINE_CAPACITY - 1);

    // Command queue between the front and back parts. The depth must be a
    // power of two so that the pointers wrap on their own.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Character codes.
    localparam logic [7:0] CHAR_BS    = 8'd8;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;

    // Command kinds handed from front to back.
    typedef enum logic [1:0] {
        OP_STORE,
        OP_BKSP,
        OP_CR
    } t_op;

    // One classified command. For a store, fill is the write index.
    // For a carriage return, fill is the line length.
    typedef struct packed {
        t_op               op;
        logic [7:0]        data;
        logic [ADDR_W-1:0] fill;
    } t_cmd;

    // One result word.
    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_byte;
        logic       line_valid;
        logic [7:0] line_byte;
        logic       line_end;
        logic       last;
    } t_result;

    // Back part sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_BUILD
    } t_back_state;

endpackage

[rtl/sle_front.sv]
// ----------------------------------------------------------------------------
// sle_front
// Accepts received bytes, classifies them and tracks the line fill count.
// ----------------------------------------------------------------------------
module sle_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rx_valid,
    output logic                       o_rx_ready,
    input  logic [7:0]                 i_rx_byte,
    output logic                       o_push,
    output sle_pkg::t_cmd              o_cmd,
    input  logic                       i_q_ready
);

    logic [sle_pkg::ADDR_W-1:0] r_fill;
    logic [sle_pkg::ADDR_W-1:0] n_fill;
    logic                       accept;

    assign o_rx_ready = i_q_ready;
    assign accept     = i_rx_valid && i_q_ready;

    // Decode the received byte into a command and the next fill count.
    always_comb begin
        n_fill     = r_fill;
        o_push     = 1'b0;
        o_cmd.op   = sle_pkg::OP_STORE;
        o_cmd.data = i_rx_byte;
        o_cmd.fill = r_fill;
        unique case (i_rx_byte)
            sle_pkg::CHAR_LF: begin
                // Line feeds are ignored.
            end
            sle_pkg::CHAR_BS: begin
                o_cmd.op = sle_pkg::OP_BKSP;
                if (r_fill != '0) begin
                    o_push = accept;
                    if (accept) begin
                        n_fill = r_fill - 1'b1;
                    end
                end
            end
            sle_pkg::CHAR_CR: begin
                o_cmd.op = sle_pkg::OP_CR;
                o_push   = accept;
                if (accept) begin
                    n_fill = '0;
                end
            end
            default: begin
                // Ordinary characters are stored while there is room.
                if (r_fill < sle_pkg::FILL_MAX) begin
                    o_push = accept;
                    if (accept) begin
                        n_fill = r_fill + 1'b1;
                    end
                end
            end
        endcase
    end

    // Fill count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

endmodule

[rtl/sle_queue.sv]
// ----------------------------------------------------------------------------
// sle_queue
// Short command queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module sle_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sle_pkg::t_cmd i_cmd,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output sle_pkg::t_cmd o_cmd
);

    sle_pkg::t_cmd               r_slot [sle_pkg::QUEUE_DEPTH];
    logic [sle_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [sle_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [sle_pkg::QCNT_W-1:0]  r_count;
    logic                        do_push;
    logic                        do_pop;

    assign o_ready = (r_count != sle_pkg::QCNT_W'(sle_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Pointer and occupancy bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Command storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[rtl/sle_back.sv]
// ----------------------------------------------------------------------------
// sle_back
// Carries out queued commands: writes the line store and produces results.
// ----------------------------------------------------------------------------
module sle_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  sle_pkg::t_cmd    i_cmd,
    output logic             o_pop,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output sle_pkg::t_result o_res
);

    sle_pkg::t_back_state r_state;
    sle_pkg::t_back_state n_state;

    logic [7:0]                 r_mem [sle_pkg::LINE_CAPACITY];
    logic [7:0]                 r_rd_data;
    sle_pkg::t_op               r_op;
    logic [7:0]                 r_byte;
    logic [sle_pkg::ADDR_W-1:0] r_fill;
    logic [sle_pkg::ADDR_W-1:0] r_k;
    logic [sle_pkg::ADDR_W-1:0] r_nline_m1;
    logic [sle_pkg::ADDR_W-1:0] r_n_m1;
    logic [sle_pkg::ADDR_W-1:0] nline_m1;
    logic                       r_out_valid;
    sle_pkg::t_result           r_out;
    sle_pkg::t_result           build;
    logic                       load;

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // Index of the result that closes the line; a carriage return ends on this or index 2, whichever is later.
    assign nline_m1 = (i_cmd.fill == '0) ? '0 : i_cmd.fill - 1'b1;

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sle_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = sle_pkg::BK_FETCH;
                end
            end
            sle_pkg::BK_FETCH: begin
                n_state = sle_pkg::BK_BUILD;
            end
            sle_pkg::BK_BUILD: begin
                if (load) begin
                    n_state = build.last ? sle_pkg::BK_IDLE : sle_pkg::BK_FETCH;
                end
            end
            default: begin
                n_state = sle_pkg::BK_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_pop = 1'b0;
        load  = 1'b0;
        unique case (r_state)
            sle_pkg::BK_IDLE: begin
                o_pop = i_q_valid;
            end
            sle_pkg::BK_FETCH: begin
            end
            sle_pkg::BK_BUILD: begin
                load = !r_out_valid || i_res_ready;
            end
            default: begin
            end
        endcase
    end

    // Build result number r_k of the current command.
    always_comb begin
        build            = '0;
        build.echo_valid = 1'b1;
        build.last       = (r_k == r_n_m1);
        unique case (r_op)
            sle_pkg::OP_STORE: begin
                build.echo_byte = r_byte;
            end
            sle_pkg::OP_BKSP: begin
                build.echo_byte = (r_k == sle_pkg::ADDR_W'(1)) ?
                                  sle_pkg::CHAR_SPACE : sle_pkg::CHAR_BS;
            end
            sle_pkg::OP_CR: begin
                build.echo_valid = (r_k < sle_pkg::ADDR_W'(3));
                if (build.echo_valid) begin
                    build.echo_byte = (r_k == sle_pkg::ADDR_W'(1)) ?
                                      sle_pkg::CHAR_LF : sle_pkg::CHAR_CR;
                end
                build.line_valid = (r_k < r_fill);
                if (build.line_valid) begin
                    build.line_byte = r_rd_data;
                end
                build.line_end = (r_k == r_nline_m1);
            end
            default: begin
                build.echo_valid = 1'b0;
            end
        endcase
    end

    // Sequencer state register and result counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sle_pkg::BK_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_k <= '0;
            end else if (load && !build.last) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    // Captured command fields.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op       <= i_cmd.op;
            r_byte     <= i_cmd.data;
            r_fill     <= i_cmd.fill;
            r_nline_m1 <= nline_m1;
            unique case (i_cmd.op)
                sle_pkg::OP_STORE: r_n_m1 <= '0;
                sle_pkg::OP_BKSP:  r_n_m1 <= sle_pkg::ADDR_W'(2);
                sle_pkg::OP_CR:    r_n_m1 <= (nline_m1 < sle_pkg::ADDR_W'(2)) ?
                                             sle_pkg::ADDR_W'(2) : nline_m1;
                default:           r_n_m1 <= '0;
            endcase
        end
    end

    // Line store: written when a store command is taken, read at r_k.
    always_ff @(posedge i_clk) begin
        if (o_pop && (i_cmd.op == sle_pkg::OP_STORE)) begin
            r_mem[i_cmd.fill] <= i_cmd.data;
        end
        r_rd_data <= r_mem[r_k];
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= build;
        end
    end

endmodule

[rtl/serial_line_editor_echo_core.sv]
// ----------------------------------------------------------------------------
// serial_line_editor_echo_core
// Serial console line editor: stores typed bytes, handles backspace and
// carriage return, and echoes back what the terminal should show.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                Payload
//  rx        in         i_rx_valid / o_rx_ready  i_rx_byte
//  res       out        o_res_valid / i_res_ready echo, line, line_end, last
//
// The front takes one word per cycle while the two-entry command queue has room.
// The back builds each result in two states (line store read in BK_FETCH, then
// result build in BK_BUILD) and pops a new command only once the current is done.
// Reset is synchronous and clears fill, queue, sequencer, r_k and output valid.
// A stalled result holds in the output register; the next result is built
// meanwhile and waits for it to be taken.
// ----------------------------------------------------------------------------
module serial_line_editor_echo_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic       o_echo_valid,
    output logic [7:0] o_echo_byte,
    output logic       o_line_valid,
    output logic [7:0] o_line_byte,
    output logic       o_line_end,
    output logic       o_last
);

    logic             push;
    logic             q_ready;
    logic             q_valid;
    logic             pop;
    sle_pkg::t_cmd    push_cmd;
    sle_pkg::t_cmd    head_cmd;
    sle_pkg::t_result res;

    // Classification and fill tracking.
    sle_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_rx_byte  (i_rx_byte),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .i_q_ready  (q_ready)
    );

    // Command queue.
    sle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    // Execution and result output.
    sle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (res)
    );

    assign o_echo_valid = res.echo_valid;
    assign o_echo_byte  = res.echo_byte;
    assign o_line_valid = res.line_valid;
    assign o_line_byte  = res.line_byte;
    assign o_line_end   = res.line_end;
    assign o_last       = res.last;

endmodule

[rtl/sle_checker.sv]
// ----------------------------------------------------------------------------
// sle_checker
// Port-level checks on the line editor result channel.
// ----------------------------------------------------------------------------
module sle_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_res_valid,
    input logic       i_res_ready,
    input logic       o_echo_valid,
    input logic [7:0] o_echo_byte,
    input logic       o_line_valid,
    input logic [7:0] o_line_byte,
    input logic       o_line_end,
    input logic       o_last
);

    // A stalled result word stays offered.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its payload.
    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=>
            $stable(o_echo_byte) && $stable(o_line_byte) && $stable(o_last) &&
            $stable(o_echo_valid) && $stable(o_line_valid) && $stable(o_line_end))
        else $error("result word changed while stalled");

    // Every result word carries something.
    a_res_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_echo_valid || o_line_valid || o_line_end))
        else $error("empty result word");

    // Fields without their valid flag read as zero.
    a_res_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> ((o_echo_valid || (o_echo_byte == 8'd0)) &&
                         (o_line_valid || (o_line_byte == 8'd0))))
        else $error("field set without its valid flag");

    // An empty line closes on the first word, next to the carriage return echo.
    a_empty_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_line_end && !o_line_valid |->
            o_echo_valid && (o_echo_byte == 8'd13))
        else $error("empty line end outside the carriage return echo");

endmodule

bind serial_line_editor_echo_core sle_checker u_sle_checker (.*);
